>>> hw/rtl/gait_event_detector_macros.svh
// assertion macros for the checker file
`ifndef GAIT_EVENT_DETECTOR_MACROS_SVH
`define GAIT_EVENT_DETECTOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define GEV_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define GEV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/gev_pkg.sv
// shared constants for the gait event detector
package gev_pkg;
    localparam int WINDOW_DEF       = 512;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int TIME_W           = 32;
    localparam int IDX_W            = 32;
    localparam int SPREAD_W         = 16;
    localparam int KIND_W           = 2;
    localparam int CFG_IDX_W        = 1;
    localparam int CFG_DATA_W       = 16;

    localparam logic [KIND_W-1:0] KIND_HEEL  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TOE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FINAL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SPREAD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE   = 1'd1;
endpackage

>>> hw/rtl/gev_if.sv
// channel interfaces: sample input, event output, configuration write
interface gev_sample_if;
    logic                                         valid;
    logic                                         ready;
    logic signed [gev_pkg::SAMPLE_WIDTH_DEF-1:0]  angular_rate;
    logic signed [gev_pkg::SAMPLE_WIDTH_DEF-1:0]  acceleration;
    logic [gev_pkg::TIME_W-1:0]                   sample_time;
    logic                                         end_of_recording;
    modport source (output valid, angular_rate, acceleration, sample_time,
                    end_of_recording, input ready);
    modport sink (input valid, angular_rate, acceleration, sample_time,
                  end_of_recording, output ready);
endinterface

interface gev_event_if;
    logic                                         valid;
    logic                                         ready;
    logic [gev_pkg::KIND_W-1:0]                   event_kind;
    logic [gev_pkg::IDX_W-1:0]                    sample_index;
    logic [gev_pkg::TIME_W-1:0]                   event_time;
    logic signed [gev_pkg::SAMPLE_WIDTH_DEF-1:0]  event_rate;
    logic                                         foot_side;
    logic                                         last_of_run;
    modport source (output valid, event_kind, sample_index, event_time, event_rate,
                    foot_side, last_of_run, input ready);
    modport sink (input valid, event_kind, sample_index, event_time, event_rate,
                  foot_side, last_of_run, output ready);
endinterface

interface gev_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [gev_pkg::CFG_IDX_W-1:0]    index;
    logic [gev_pkg::CFG_DATA_W-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/gait_event_detector.sv
// gait event detector: heel contact and toe-off from foot gyroscope samples
//
// channels: sample_in takes one sample transaction (rate, acceleration,
// timestamp, end flag); event_out gives zero to three event transactions per
// sample, the last of them marked by last_of_run; cfg writes spread (index 0)
// and side_is_left (index 1), always ready; the user is to write cfg only
// while the block is idle; the block itself does not enforce this.
// per sample: a sample without events passes take, peak update and end
// check before the next one is taken; each labelled event adds a label
// step plus an output step, the final event an output step, and a heel
// contact with correction adds a walk back through the sample ring, one
// entry per cycle, up to WINDOW entries. the worst case is when one sample
// ends a swing peak and the recording and both labelled events are
// corrected heel contacts; the walk uses the single read port of the ring.
// the ring holds the last WINDOW samples (time, acceleration, rate) and is
// written once per accepted sample transaction.
// reset: all control state, counters, peak and held events cleared; the ring
// is not cleared (entries are only read once written in the current run).
// when event_out stalls, the result register holds and no new sample is taken.
module gait_event_detector #(
    parameter int WINDOW       = gev_pkg::WINDOW_DEF
) (
    input  logic clk,
    input  logic rst_n,
    gev_sample_if.sink  sample_in,
    gev_event_if.source event_out,
    gev_cfg_if.sink     cfg
);
    localparam int AW = $clog2(WINDOW);
    localparam int SW = gev_pkg::SAMPLE_WIDTH_DEF;
    localparam int EW = gev_pkg::TIME_W + 2 * SW;
    localparam int CW = SW + 20;
    localparam int IW = gev_pkg::IDX_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PEAK = 3'd1;
    localparam logic [2:0] S_END  = 3'd2;
    localparam logic [2:0] S_LBL  = 3'd3;
    localparam logic [2:0] S_SRCH = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    typedef struct packed {
        logic [IW-1:0]                  idx;
        logic [gev_pkg::TIME_W-1:0]     tm;
        logic signed [SW-1:0]           rate;
    } ev_t;

    typedef struct packed {
        logic [gev_pkg::TIME_W-1:0]     tm;
        logic signed [SW-1:0]           acc;
        logic signed [SW-1:0]           rate;
    } ent_t;

    // sample ring
    logic [EW-1:0] ring_mem [WINDOW];
    ent_t          rdata_reg;
    logic [AW-1:0] raddr;

    logic [2:0]               state_reg;
    logic [gev_pkg::SPREAD_W-1:0] spread_reg;
    logic                     side_reg;
    logic [IW-1:0]            cnt_reg;
    logic [IW-1:0]            cur_reg;
    logic [AW-1:0]            pos_reg;
    logic [AW-1:0]            pos_next;
    logic signed [SW-1:0]     rate_reg;
    logic [gev_pkg::TIME_W-1:0] time_reg;
    logic                     end_reg;

    // swing peak tracker
    ev_t                      peak_reg;
    logic                     peak_act_reg;

    // held events and emission bookkeeping
    ev_t                      h0_reg;
    ev_t                      h1_reg;
    logic [1:0]               hcnt_reg;
    ev_t                      pend_reg;
    logic                     append_reg;
    logic                     from_end_reg;
    logic [IW-1:0]            prev_idx_reg;
    logic                     any_reg;

    // heel contact search
    ev_t                      e_reg;
    logic [AW:0]              ak_reg;
    logic [AW:0]              n_reg;
    logic [AW-1:0]            addr_reg;
    logic [AW-1:0]            addr_next;
    logic [AW-1:0]            addr_age;
    logic                     have_prev_reg;
    ent_t                     prev_reg;

    // result register
    logic [gev_pkg::KIND_W-1:0] o_kind_reg;
    ev_t                      o_ev_reg;
    logic                     o_last_reg;

    // decode
    logic                     in_acc;
    logic signed [CW-1:0]     rate_x;
    logic signed [CW-1:0]     neg_s;
    logic signed [CW-1:0]     sprd_x;
    logic signed [CW-1:0]     diff_x;
    logic signed [CW-1:0]     absd_x;
    logic                     below;
    logic                     recover;
    logic                     far;
    ev_t                      last_h;
    logic [IW-1:0]            age;
    logic [IW-1:0]            span;
    logic                     heel;
    logic                     hit;
    logic [AW:0]              age_sum;

    assign in_acc  = sample_in.valid && sample_in.ready;
    assign pos_next = (pos_reg == AW'(WINDOW - 1)) ? '0 : pos_reg + 1'b1;
    assign addr_next = (addr_reg == '0) ? AW'(WINDOW - 1) : addr_reg - 1'b1;

    assign rate_x  = CW'(rate_reg);
    assign sprd_x  = CW'($signed({1'b0, spread_reg}));
    assign neg_s   = -sprd_x;
    assign below   = (rate_x <<< 1) < neg_s;
    assign recover = (rate_x * CW'(5)) > neg_s;
    assign last_h  = (hcnt_reg == 2'd2) ? h1_reg : h0_reg;
    assign diff_x  = CW'(last_h.rate) - CW'(peak_reg.rate);
    assign absd_x  = diff_x[CW-1] ? -diff_x : diff_x;
    assign far     = (absd_x <<< 1) > sprd_x;

    assign age  = cur_reg - h0_reg.idx;
    assign span = h0_reg.idx - prev_idx_reg;
    assign heel = h0_reg.rate > h1_reg.rate;
    // ring position of the sample at this age, age below WINDOW
    assign age_sum  = {1'b0, pos_reg} + (AW+1)'(WINDOW) - (AW+1)'(age[AW-1:0]);
    assign addr_age = ({1'b0, pos_reg} >= (AW+1)'(age[AW-1:0])) ?
                      (pos_reg - age[AW-1:0]) : age_sum[AW-1:0];
    // acceleration drop below zero
    assign hit = (prev_reg.acc < rdata_reg.acc) && (prev_reg.acc < 0);

    always_comb
    begin
        case (state_reg)
            S_LBL:   raddr = addr_age;
            S_SRCH:  raddr = addr_next;
            default: raddr = addr_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            ring_mem[pos_next] <= {sample_in.sample_time, sample_in.acceleration,
                                   sample_in.angular_rate};
        end
        rdata_reg <= ring_mem[raddr];
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spread_reg <= '0;
            side_reg   <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                gev_pkg::REG_SPREAD: spread_reg <= cfg.data;
                gev_pkg::REG_SIDE:   side_reg   <= cfg.data[0];
                default:             side_reg   <= side_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            cur_reg       <= '0;
            pos_reg       <= '0;
            rate_reg      <= '0;
            time_reg      <= '0;
            peak_reg      <= '0;
            peak_act_reg  <= 1'b0;
            h0_reg        <= '0;
            h1_reg        <= '0;
            hcnt_reg      <= '0;
            pend_reg      <= '0;
            append_reg    <= 1'b0;
            from_end_reg  <= 1'b0;
            prev_idx_reg  <= '0;
            any_reg       <= 1'b0;
            e_reg         <= '0;
            ak_reg        <= '0;
            n_reg         <= '0;
            addr_reg      <= '0;
            have_prev_reg <= 1'b0;
            prev_reg      <= '0;
            o_kind_reg    <= gev_pkg::KIND_HEEL;
            o_ev_reg      <= '0;
            o_last_reg    <= 1'b0;
            end_reg       <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        pos_reg  <= pos_next;
                        rate_reg <= sample_in.angular_rate;
                        time_reg <= sample_in.sample_time;
                        end_reg  <= sample_in.end_of_recording;
                        cur_reg  <= cnt_reg;
                        cnt_reg  <= cnt_reg + 1'b1;
                        state_reg <= S_PEAK;
                    end
                end
                S_PEAK:
                begin
                    state_reg <= S_END;
                    if (below)
                    begin
                        if (rate_reg < peak_reg.rate)
                        begin
                            peak_reg     <= '{idx: cur_reg, tm: time_reg, rate: rate_reg};
                            peak_act_reg <= 1'b1;
                        end
                    end
                    else if (recover && peak_act_reg)
                    begin
                        // swing peak ended: becomes an event
                        if (hcnt_reg == 2'd0)
                        begin
                            h0_reg   <= peak_reg;
                            hcnt_reg <= 2'd1;
                        end
                        else if (far)
                        begin
                            if (hcnt_reg == 2'd2)
                            begin
                                pend_reg     <= peak_reg;
                                append_reg   <= 1'b1;
                                from_end_reg <= 1'b0;
                                state_reg    <= S_LBL;
                            end
                            else
                            begin
                                h1_reg   <= peak_reg;
                                hcnt_reg <= 2'd2;
                            end
                        end
                        else if (hcnt_reg == 2'd2)
                        begin
                            h1_reg <= peak_reg;
                        end
                        else
                        begin
                            h0_reg <= peak_reg;
                        end
                        peak_reg     <= '0;
                        peak_act_reg <= 1'b0;
                    end
                end
                S_END:
                begin
                    if (!end_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (hcnt_reg == 2'd2)
                    begin
                        from_end_reg <= 1'b1;
                        state_reg    <= S_LBL;
                    end
                    else if (hcnt_reg == 2'd1)
                    begin
                        o_kind_reg <= gev_pkg::KIND_FINAL;
                        o_ev_reg   <= h0_reg;
                        o_last_reg <= 1'b1;
                        state_reg  <= S_OUT;
                    end
                    else
                    begin
                        cnt_reg      <= '0;
                        peak_reg     <= '0;
                        peak_act_reg <= 1'b0;
                        prev_idx_reg <= '0;
                        any_reg      <= 1'b0;
                        state_reg    <= S_IDLE;
                    end
                end
                S_LBL:
                begin
                    o_last_reg <= from_end_reg ? 1'b0 : !end_reg;
                    e_reg      <= h0_reg;
                    ak_reg     <= age[AW:0];
                    n_reg      <= '0;
                    addr_reg   <= addr_age;
                    have_prev_reg <= 1'b0;
                    if (heel && any_reg && (age < IW'(WINDOW - 1)) && (span != '0))
                    begin
                        state_reg <= S_SRCH;
                    end
                    else
                    begin
                        o_kind_reg <= heel ? gev_pkg::KIND_HEEL : gev_pkg::KIND_TOE;
                        o_ev_reg   <= h0_reg;
                        state_reg  <= S_OUT;
                    end
                end
                S_SRCH:
                begin
                    addr_reg <= addr_next;
                    if (!have_prev_reg)
                    begin
                        prev_reg      <= rdata_reg;
                        have_prev_reg <= 1'b1;
                    end
                    else if (hit)
                    begin
                        o_kind_reg <= gev_pkg::KIND_HEEL;
                        o_ev_reg   <= '{idx: e_reg.idx - IW'(n_reg), tm: prev_reg.tm,
                                        rate: prev_reg.rate};
                        state_reg  <= S_OUT;
                    end
                    else if ((IW'(n_reg) + 1'b1 < span) &&
                             (ak_reg + 2'd2 < (AW+1)'(WINDOW)))
                    begin
                        prev_reg <= rdata_reg;
                        n_reg    <= n_reg + 1'b1;
                        ak_reg   <= ak_reg + 1'b1;
                    end
                    else
                    begin
                        o_kind_reg <= gev_pkg::KIND_HEEL;
                        o_ev_reg   <= e_reg;
                        state_reg  <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (event_out.ready)
                    begin
                        if (o_kind_reg == gev_pkg::KIND_FINAL)
                        begin
                            // end of recording: clear the run
                            hcnt_reg     <= '0;
                            cnt_reg      <= '0;
                            peak_reg     <= '0;
                            peak_act_reg <= 1'b0;
                            prev_idx_reg <= '0;
                            any_reg      <= 1'b0;
                            state_reg    <= S_IDLE;
                        end
                        else
                        begin
                            prev_idx_reg <= o_ev_reg.idx;
                            any_reg      <= 1'b1;
                            h0_reg       <= h1_reg;
                            if (append_reg)
                            begin
                                h1_reg     <= pend_reg;
                                hcnt_reg   <= 2'd2;
                                append_reg <= 1'b0;
                            end
                            else
                            begin
                                hcnt_reg <= 2'd1;
                            end
                            state_reg <= S_END;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign sample_in.ready        = (state_reg == S_IDLE);
    assign cfg.ready              = 1'b1;
    assign event_out.valid        = (state_reg == S_OUT);
    assign event_out.event_kind   = o_kind_reg;
    assign event_out.sample_index = o_ev_reg.idx;
    assign event_out.event_time   = o_ev_reg.tm;
    assign event_out.event_rate   = o_ev_reg.rate;
    assign event_out.foot_side    = side_reg;
    assign event_out.last_of_run  = o_last_reg;
endmodule

>>> hw/rtl/gev_checker.sv
// port-level checks for the gait event detector, bound to the top level
`include "gait_event_detector_macros.svh"

module gev_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [gev_pkg::KIND_W-1:0]  out_kind,
    input logic [gev_pkg::IDX_W-1:0]   out_idx,
    input logic                        out_last
);
    // one sample at a time: no new sample while a result is shown
    `GEV_ASSERT_NOW(a_no_overlap, out_valid, !in_ready)
    // after a sample is taken the block is busy in the next cycle
    `GEV_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)
    // kind code stays within its defined set
    `GEV_ASSERT_NOW(a_kind_legal, out_valid, out_kind <= gev_pkg::KIND_FINAL)
    // the unlabelled final event closes the run
    `GEV_ASSERT_NOW(a_final_last, out_valid && out_kind == gev_pkg::KIND_FINAL, out_last)
    // stalled result holds
    `GEV_ASSERT_NEXT(a_hold, out_valid && !out_ready,
        out_valid && $stable(out_kind) && $stable(out_idx) && $stable(out_last))
endmodule

bind gait_event_detector gev_checker u_gev_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample_in.valid),
    .in_ready  (sample_in.ready),
    .out_valid (event_out.valid),
    .out_ready (event_out.ready),
    .out_kind  (event_out.event_kind),
    .out_idx   (event_out.sample_index),
    .out_last  (event_out.last_of_run)
);
